// File: rtl/core/record_header_validator_defines.svh
// ----------------------------------------------------------------------------
// Record header validator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_HEADER_VALIDATOR_DEFINES_SVH
`define RECORD_HEADER_VALIDATOR_DEFINES_SVH

// Same-cycle implication
`define RHV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RHV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rhv_pkg.sv
// ----------------------------------------------------------------------------
// rhv_pkg
// Shared constants, types and helper functions of the record header validator.
// ----------------------------------------------------------------------------
`default_nettype none

package rhv_pkg;

  // Record layout
  localparam int unsigned MAX_PAYLOAD = 136;
  localparam int unsigned HDR_LEN     = 24;
  localparam int unsigned MAGIC_END   = 8;
  localparam int unsigned GEN_END     = 16;
  localparam int unsigned DATE_END    = 20;
  localparam int unsigned COUNT_SAT   = HDR_LEN + MAX_PAYLOAD + 1;
  localparam int unsigned CNT_W       = $clog2(COUNT_SAT + 1);

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] MAGIC_BYTES [8] = '{
    8'h44, 8'h52, 8'h57, 8'h54, 8'h48, 8'h30, 8'h30, 8'h31
  };

  // Date decode: yyyymmdd, years 2000..2099
  localparam logic [31:0] DATE_LO     = 32'd20000000;
  localparam logic [31:0] DATE_HI     = 32'd20999999;
  localparam int unsigned YEAR_SCALE  = 10000;
  localparam int unsigned MONTH_SCALE = 100;
  // floor(2^34 / 10000) and floor(2^20 / 100); estimates are low by at most one
  localparam int unsigned DIV10K_MUL  = 1717986;
  localparam int unsigned DIV10K_SH   = 34;
  localparam int unsigned DIV100_MUL  = 10485;
  localparam int unsigned DIV100_SH   = 20;

  // Result codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_ZERO_GEN = 3'd3,
    ERR_CHECKSUM = 3'd4,
    ERR_DATE     = 3'd5
  } err_code_t;

  // Header tracking state, as seen after one byte is applied
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [31:0]      crc;
    logic             magic_match;
    logic [63:0]      generation;
    logic [31:0]      date;
    logic [31:0]      stored_crc;
  } hdr_state_t;

  localparam hdr_state_t HDR_RESET = '{
    count:       '0,
    crc:         CRC_INIT,
    magic_match: 1'b1,
    generation:  '0,
    date:        '0,
    stored_crc:  '0
  };

  // One byte through the CRC, bit at a time
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Days in a month; zero for a month number outside 1..12
  function automatic logic [4:0] days_in_month(input logic [6:0] month, input logic leap);
    logic [4:0] lim;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     lim = 5'd30;
      7'd2:                                        lim = leap ? 5'd29 : 5'd28;
      default:                                     lim = 5'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/record_header_validator.sv
// ----------------------------------------------------------------------------
// record_header_validator
// Checks the header of a stored record streamed one byte per request.
// ----------------------------------------------------------------------------
// One byte is taken every clock while in_stall is low. The result request
// for a record appears in the cycle after its last byte is taken and waits
// in the output register; in_stall rises only while that register is full
// and out_stall is high. CRC update, magic compare and field capture all
// finish in the cycle a byte is taken. The date is decoded by a four-stage
// pipeline that starts once header byte 19 is in; the four checksum bytes
// give it the time it needs, so no record is held up for it.
`default_nettype none

module record_header_validator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  // Result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_record_ok,
  output logic [2:0]       out_error_code,
  output logic [63:0]      out_generation,
  output logic [31:0]      out_date_value,
  output logic [7:0]       out_payload_length
);

`include "record_header_validator_defines.svh"

  rhv_pkg::hdr_state_t upd;
  logic [31:0]         date_q;
  logic                date_valid;
  logic                in_take;
  logic                len_bad;
  logic [7:0]          plen;
  rhv_pkg::err_code_t  err_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  rhv_pkg::err_code_t  err_r;
  logic [63:0]         gen_r;
  logic [31:0]         date_r;
  logic [7:0]          plen_r;

  // Handshake
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  rhv_hdr_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .upd       (upd),
    .date_q    (date_q)
  );

  rhv_date_check u_date (
    .clk        (clk),
    .date       (date_q),
    .date_valid (date_valid)
  );

  // Length and payload size
  assign len_bad = (upd.count <= rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN)) ||
                   (upd.count > rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN + rhv_pkg::MAX_PAYLOAD));
  assign plen    = (upd.count > rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN)) ?
                   8'(upd.count - rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN)) : 8'd0;

  // First failing check wins
  always_comb begin
    err_nxt = rhv_pkg::ERR_NONE;
    if (len_bad) begin
      err_nxt = rhv_pkg::ERR_LENGTH;
    end else if (!upd.magic_match) begin
      err_nxt = rhv_pkg::ERR_MAGIC;
    end else if (upd.generation == 64'd0) begin
      err_nxt = rhv_pkg::ERR_ZERO_GEN;
    end else if (~upd.crc != upd.stored_crc) begin
      err_nxt = rhv_pkg::ERR_CHECKSUM;
    end else if (!date_valid) begin
      err_nxt = rhv_pkg::ERR_DATE;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_last_byte) begin
      err_r  <= err_nxt;
      gen_r  <= upd.generation;
      date_r <= upd.date;
      plen_r <= plen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_ok      = (err_r == rhv_pkg::ERR_NONE);
  assign out_error_code     = err_r;
  assign out_generation     = gen_r;
  assign out_date_value     = date_r;
  assign out_payload_length = plen_r;

  // Checks
  `RHV_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid, "input stalled with no result held")
  `RHV_ASSERT_NEXT(a_last_gives_result, in_valid && !in_stall && in_last_byte, out_valid, "no result after last byte")
  `RHV_ASSERT_SAME(a_ok_len_in_range, out_valid && (out_error_code != rhv_pkg::ERR_LENGTH), (out_payload_length >= 8'd1) && (out_payload_length <= 8'(rhv_pkg::MAX_PAYLOAD)), "payload length out of range without length error")
  `RHV_ASSERT_SAME(a_ok_gen_nonzero, out_valid && out_record_ok, out_generation != 64'd0, "record ok with zero generation")

endmodule

`default_nettype wire

// File: rtl/core/rhv_hdr_capture.sv
// ----------------------------------------------------------------------------
// rhv_hdr_capture
// Byte counter, running CRC, magic compare and header field capture.
// ----------------------------------------------------------------------------
`default_nettype none

module rhv_hdr_capture (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output rhv_pkg::hdr_state_t     upd,
  output logic [31:0]             date_q
);

  rhv_pkg::hdr_state_t state_r;
  rhv_pkg::hdr_state_t state_nxt;
  logic [rhv_pkg::CNT_W-1:0] idx;

  assign idx    = state_r.count;
  assign date_q = state_r.date;

  // State after the current byte
  always_comb begin
    upd = state_r;
    // CRC skips the stored checksum bytes
    if ((idx < rhv_pkg::CNT_W'(rhv_pkg::DATE_END)) ||
        (idx >= rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN))) begin
      upd.crc = rhv_pkg::crc32_byte(state_r.crc, data_byte);
    end
    if (idx < rhv_pkg::CNT_W'(rhv_pkg::MAGIC_END)) begin
      if (data_byte != rhv_pkg::MAGIC_BYTES[idx[2:0]]) begin
        upd.magic_match = 1'b0;
      end
    end else if (idx < rhv_pkg::CNT_W'(rhv_pkg::GEN_END)) begin
      upd.generation[{idx[2:0], 3'b000} +: 8] = data_byte;
    end else if (idx < rhv_pkg::CNT_W'(rhv_pkg::DATE_END)) begin
      upd.date[{idx[1:0], 3'b000} +: 8] = data_byte;
    end else if (idx < rhv_pkg::CNT_W'(rhv_pkg::HDR_LEN)) begin
      upd.stored_crc[{idx[1:0], 3'b000} +: 8] = data_byte;
    end
    // Saturating byte count
    if (idx < rhv_pkg::CNT_W'(rhv_pkg::COUNT_SAT)) begin
      upd.count = idx + rhv_pkg::CNT_W'(1);
    end
  end

  // Last byte starts a fresh record
  always_comb begin
    state_nxt = state_r;
    if (take) begin
      state_nxt = last_byte ? rhv_pkg::HDR_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhv_pkg::HDR_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rhv_date_check.sv
// ----------------------------------------------------------------------------
// rhv_date_check
// Four-stage decode of a yyyymmdd word into year, month and day, with a
// calendar check on the last stage's registers. Runs every clock.
// ----------------------------------------------------------------------------
`default_nettype none

module rhv_date_check (
  input  wire logic        clk,
  input  wire logic [31:0] date,
  output logic             date_valid
);

  // Stage 1: year range and offset into the century
  logic        s1_in_range_r;
  logic [19:0] s1_rem_r;
  // Stage 2: year estimate
  logic        s2_in_range_r;
  logic [19:0] s2_rem_r;
  logic [6:0]  s2_year_r;
  // Stage 3: leap flag of the corrected year and month/day remainder
  logic        s3_in_range_r;
  logic [13:0] s3_rem_r;
  logic        s3_leap_r;
  // Stage 4: month estimate
  logic        s4_in_range_r;
  logic [13:0] s4_rem_r;
  logic        s4_leap_r;
  logic [6:0]  s4_month_r;

  logic [40:0] year_prod;
  logic [20:0] year_rem;
  logic [6:0]  year_fix;
  logic [13:0] mmdd_fix;
  logic [27:0] month_prod;
  logic [13:0] day_raw;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [4:0]  lim;

  // Year: multiply by reciprocal, then one correction step
  assign year_prod = 41'(s1_rem_r) * 41'(rhv_pkg::DIV10K_MUL);
  assign year_rem  = 21'(s2_rem_r) - 21'(s2_year_r) * 21'(rhv_pkg::YEAR_SCALE);

  always_comb begin
    year_fix = s2_year_r;
    mmdd_fix = year_rem[13:0];
    if (year_rem >= 21'(rhv_pkg::YEAR_SCALE)) begin
      year_fix = s2_year_r + 7'd1;
      mmdd_fix = 14'(year_rem - 21'(rhv_pkg::YEAR_SCALE));
    end
  end

  assign month_prod = 28'(s3_rem_r) * 28'(rhv_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    s1_in_range_r <= (date >= rhv_pkg::DATE_LO) && (date <= rhv_pkg::DATE_HI);
    s1_rem_r      <= 20'(date - rhv_pkg::DATE_LO);

    s2_in_range_r <= s1_in_range_r;
    s2_rem_r      <= s1_rem_r;
    s2_year_r     <= year_prod[rhv_pkg::DIV10K_SH +: 7];

    s3_in_range_r <= s2_in_range_r;
    s3_rem_r      <= mmdd_fix;
    // Century years other than 2000 are outside the range
    s3_leap_r     <= (year_fix[1:0] == 2'b00);

    s4_in_range_r <= s3_in_range_r;
    s4_rem_r      <= s3_rem_r;
    s4_leap_r     <= s3_leap_r;
    s4_month_r    <= month_prod[rhv_pkg::DIV100_SH +: 7];
  end

  // Month/day split correction and calendar check
  assign day_raw = s4_rem_r - 14'(s4_month_r) * 14'(rhv_pkg::MONTH_SCALE);

  always_comb begin
    month = s4_month_r;
    day   = day_raw[6:0];
    if (day_raw >= 14'(rhv_pkg::MONTH_SCALE)) begin
      month = s4_month_r + 7'd1;
      day   = 7'(day_raw - 14'(rhv_pkg::MONTH_SCALE));
    end
  end

  assign lim        = rhv_pkg::days_in_month(month, s4_leap_r);
  assign date_valid = s4_in_range_r && (day != 7'd0) && (day <= 7'(lim));

endmodule

`default_nettype wire
